// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/vn_pkg.sv -----
// Shared sizes, payload structs and pipeline stage records for vec2_normalize_fixed.
// No dependencies.
package vn_pkg;

  localparam int IN_WIDTH      = 32;
  localparam int OUT_FRAC_BITS = 30;
  localparam int FIELD_W       = 32;
  localparam int SUM_W         = 2 * IN_WIDTH;
  localparam int ROOT_W        = IN_WIDTH;
  localparam int QUO_W         = OUT_FRAC_BITS + 1;

  localparam logic [QUO_W-1:0] Q_LIMIT = QUO_W'(1) << OUT_FRAC_BITS;
  localparam logic signed [FIELD_W-1:0] UNIT_MAX = FIELD_W'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_component;
    logic signed [FIELD_W-1:0] y_component;
  } item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] unit_x;
    logic signed [FIELD_W-1:0] unit_y;
    logic        [FIELD_W-1:0] length;
    logic                      is_zero;
  } result_t;

  // Squared magnitude plus component magnitudes and signs.
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [IN_WIDTH-1:0] ax;
    logic [IN_WIDTH-1:0] ay;
    logic                nx;
    logic                ny;
  } mag_t;

  // One square-root stage.
  typedef struct packed {
    logic [ROOT_W+1:0]   rem;
    logic [ROOT_W-1:0]   root;
    logic [SUM_W-1:0]    sum;
    logic [IN_WIDTH-1:0] ax;
    logic [IN_WIDTH-1:0] ay;
    logic                nx;
    logic                ny;
  } sqs_t;

  // One divider stage, both lanes.
  typedef struct packed {
    logic [ROOT_W:0]   rx;
    logic [ROOT_W:0]   ry;
    logic [QUO_W-1:0]  qx;
    logic [QUO_W-1:0]  qy;
    logic [ROOT_W-1:0] len;
    logic              nx;
    logic              ny;
  } dvs_t;

endpackage

// ----- rtl/vn_square.sv -----
// Front end: sign split, squaring and sum of squares, three register stages.
// Depends on vn_pkg.
module vn_square (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  vn_pkg::item_t in_data,
  output logic          out_valid,
  output vn_pkg::mag_t  out_data
);

  logic [vn_pkg::IN_WIDTH-1:0] xs, ys;
  logic                        v1, v2;
  logic [vn_pkg::IN_WIDTH-1:0] ax1, ay1, ax2, ay2;
  logic                        nx1, ny1, nx2, ny2;
  logic [vn_pkg::SUM_W-1:0]    sqx, sqy;

  assign xs = in_data.x_component[vn_pkg::IN_WIDTH-1:0];
  assign ys = in_data.y_component[vn_pkg::IN_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    if (ce) begin
      nx1 <= xs[vn_pkg::IN_WIDTH-1];
      ny1 <= ys[vn_pkg::IN_WIDTH-1];
      ax1 <= xs[vn_pkg::IN_WIDTH-1] ? (~xs + 1'b1) : xs;
      ay1 <= ys[vn_pkg::IN_WIDTH-1] ? (~ys + 1'b1) : ys;
      // square each magnitude
      ax2 <= ax1;
      ay2 <= ay1;
      nx2 <= nx1;
      ny2 <= ny1;
      sqx <= vn_pkg::SUM_W'(ax1) * vn_pkg::SUM_W'(ax1);
      sqy <= vn_pkg::SUM_W'(ay1) * vn_pkg::SUM_W'(ay1);
      // sum cannot overflow: each square is at most 2^(2*IN_WIDTH-2)
      out_data.sum <= sqx + sqy;
      out_data.ax  <= ax2;
      out_data.ay  <= ay2;
      out_data.nx  <= nx2;
      out_data.ny  <= ny2;
    end
  end

endmodule

// ----- rtl/vn_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on vn_pkg.
module vn_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  vn_pkg::mag_t  in_data,
  output logic          out_valid,
  output vn_pkg::sqs_t  out_data
);

  localparam int N = vn_pkg::ROOT_W;

  vn_pkg::sqs_t st  [N];
  logic         vld [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    vn_pkg::sqs_t prev;
    logic         prev_v;
    logic [vn_pkg::ROOT_W+1:0] rem_sh, trial;
    logic                      ge;

    if (k == 0) begin : g_first
      assign prev_v    = in_valid;
      assign prev.rem  = '0;
      assign prev.root = '0;
      assign prev.sum  = in_data.sum;
      assign prev.ax   = in_data.ax;
      assign prev.ay   = in_data.ay;
      assign prev.nx   = in_data.nx;
      assign prev.ny   = in_data.ny;
    end else begin : g_next
      assign prev_v = vld[k-1];
      assign prev   = st[k-1];
    end

    // bring down the next two bits and try root*4+1
    assign rem_sh = {prev.rem[vn_pkg::ROOT_W-1:0], prev.sum[vn_pkg::SUM_W-1 -: 2]};
    assign trial  = {prev.root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= prev_v;
      end
      if (ce) begin
        st[k].rem  <= ge ? (rem_sh - trial) : rem_sh;
        st[k].root <= {prev.root[vn_pkg::ROOT_W-2:0], ge};
        st[k].sum  <= prev.sum << 2;
        st[k].ax   <= prev.ax;
        st[k].ay   <= prev.ay;
        st[k].nx   <= prev.nx;
        st[k].ny   <= prev.ny;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_data  = st[N-1];

endmodule

// ----- rtl/vn_div.sv -----
// Pipelined restoring divider for both unit components, one quotient bit per stage.
// Depends on vn_pkg.
module vn_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  vn_pkg::sqs_t  in_data,
  output logic          out_valid,
  output vn_pkg::dvs_t  out_data
);

  localparam int N = vn_pkg::QUO_W;

  vn_pkg::dvs_t st  [N];
  logic         vld [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    vn_pkg::dvs_t prev;
    logic         prev_v;
    logic         bx, by;
    logic [vn_pkg::ROOT_W:0] sx, sy, dd;
    logic                    gx, gy;

    if (k == 0) begin : g_first
      // numerator is a << OUT_FRAC_BITS; start from a >> 1, then shift in a[0]
      assign prev_v   = in_valid;
      assign prev.rx  = {1'b0, in_data.ax >> 1};
      assign prev.ry  = {1'b0, in_data.ay >> 1};
      assign prev.qx  = '0;
      assign prev.qy  = '0;
      assign prev.len = in_data.root;
      assign prev.nx  = in_data.nx;
      assign prev.ny  = in_data.ny;
      assign bx       = in_data.ax[0];
      assign by       = in_data.ay[0];
    end else begin : g_next
      assign prev_v = vld[k-1];
      assign prev   = st[k-1];
      assign bx     = 1'b0;
      assign by     = 1'b0;
    end

    assign dd = {1'b0, prev.len};
    assign sx = {prev.rx[vn_pkg::ROOT_W-1:0], bx};
    assign sy = {prev.ry[vn_pkg::ROOT_W-1:0], by};
    assign gx = (sx >= dd);
    assign gy = (sy >= dd);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= prev_v;
      end
      if (ce) begin
        st[k].rx  <= gx ? (sx - dd) : sx;
        st[k].ry  <= gy ? (sy - dd) : sy;
        st[k].qx  <= {prev.qx[vn_pkg::QUO_W-2:0], gx};
        st[k].qy  <= {prev.qy[vn_pkg::QUO_W-2:0], gy};
        st[k].len <= prev.len;
        st[k].nx  <= prev.nx;
        st[k].ny  <= prev.ny;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_data  = st[N-1];

endmodule

// ----- rtl/vec2_normalize_fixed.sv -----
// Top level of the 2D vector normalizer: front end, square root, divider, output register.
// Depends on vn_pkg, vn_square, vn_sqrt, vn_div.
//
//   channel | signals                              | payload
//   --------+--------------------------------------+------------------------------
//   input   | item_valid, item_ready, item         | x/y components, Q16.16
//   output  | result_valid, result_ready, result   | unit x/y Q2.30, length, zero
//
// One transaction per cycle sustained while the output is not stalled; between input and
// output lie the front end, the one-bit-per-stage root and divider pipelines and the output register.
// Synchronous active-high reset clears every stage valid bit; payload is not reset.
// A stall on the output holds the whole pipeline in place; item_ready drops with it.
module vec2_normalize_fixed (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  vn_pkg::item_t   item,
  output logic            result_valid,
  input  logic            result_ready,
  output vn_pkg::result_t result
);

  logic          ce;
  logic          mag_v, sqrt_v, div_v;
  vn_pkg::mag_t  mag;
  vn_pkg::sqs_t  sqr;
  vn_pkg::dvs_t  dv;

  logic                          zero;
  logic [vn_pkg::QUO_W-1:0]      qx_sat, qy_sat;
  logic [vn_pkg::FIELD_W-1:0]    ux, uy;
  vn_pkg::result_t               result_next;

  // advance everything unless a finished result is waiting
  assign ce         = ~result_valid | result_ready;
  assign item_ready = ce;

  vn_square u_square (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(item_valid), .in_data(item),
    .out_valid(mag_v), .out_data(mag)
  );

  vn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(mag_v), .in_data(mag),
    .out_valid(sqrt_v), .out_data(sqr)
  );

  vn_div u_div (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(sqrt_v), .in_data(sqr),
    .out_valid(div_v), .out_data(dv)
  );

  // clamp, apply sign, force zero vector to zero
  always_comb begin
    zero   = (dv.len == '0);
    qx_sat = (dv.qx > vn_pkg::Q_LIMIT) ? vn_pkg::Q_LIMIT : dv.qx;
    qy_sat = (dv.qy > vn_pkg::Q_LIMIT) ? vn_pkg::Q_LIMIT : dv.qy;
    ux     = vn_pkg::FIELD_W'(qx_sat);
    uy     = vn_pkg::FIELD_W'(qy_sat);
    result_next.unit_x  = zero ? '0 : (dv.nx ? (~ux + 1'b1) : ux);
    result_next.unit_y  = zero ? '0 : (dv.ny ? (~uy + 1'b1) : uy);
    result_next.length  = vn_pkg::FIELD_W'(dv.len);
    result_next.is_zero = zero;
  end

  // output register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ce) begin
      result_valid <= div_v;
    end
    if (ce) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/vn_checker.sv -----
// Port-level checker for vec2_normalize_fixed, attached by bind.
// Depends on vn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vn_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            result_valid,
  input  logic            result_ready,
  input  vn_pkg::result_t result
);

  `ASSERT_CLK(a_hold, clk, rst, result_valid && !result_ready |=> result_valid, "result dropped while stalled")
  `ASSERT_CLK(a_zero, clk, rst, result_valid && result.is_zero |-> result.unit_x == 0 && result.unit_y == 0 && result.length == 0, "zero vector with nonzero outputs")
  `ASSERT_CLK(a_range, clk, rst, result_valid |-> result.unit_x <= vn_pkg::UNIT_MAX && result.unit_x >= -vn_pkg::UNIT_MAX && result.unit_y <= vn_pkg::UNIT_MAX && result.unit_y >= -vn_pkg::UNIT_MAX, "unit component out of range")
  `ASSERT_ALWAYS(a_reset, clk, $past(rst) |-> !result_valid, "result valid right after reset")

endmodule

bind vec2_normalize_fixed vn_checker u_vn_checker (
  .clk(clk), .rst(rst),
  .result_valid(result_valid), .result_ready(result_ready), .result(result)
);

// ----- tb/vec2_normalize_fixed_tb.sv -----
// Testbench for vec2_normalize_fixed: drives vectors, predicts unit vector and length.
// Depends on vn_pkg and the vec2_normalize_fixed RTL.
module vec2_normalize_fixed_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Floor square root of a 64-bit value, one bit per pass.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned b;
    rem = v;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Scale one component to the unit range, truncate toward zero, saturate.
  function automatic logic [vn_pkg::FIELD_W-1:0] scale_component(
      logic [vn_pkg::IN_WIDTH-1:0] raw, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    logic neg;
    logic [vn_pkg::IN_WIDTH-1:0] neg_raw;
    neg = raw[vn_pkg::IN_WIDTH-1];
    // negate at the field width, then widen
    neg_raw = (~raw) + 1'b1;
    mag = neg ? 64'(neg_raw) : 64'(raw);
    if (len == 0) return '0;
    q = (mag << vn_pkg::OUT_FRAC_BITS) / len;
    if (q > (64'd1 << vn_pkg::OUT_FRAC_BITS)) q = 64'd1 << vn_pkg::OUT_FRAC_BITS;
    if (neg) q = ~q + 1;
    return q[vn_pkg::FIELD_W-1:0];
  endfunction

  function automatic vn_pkg::result_t normalize_vector(vn_pkg::item_t v);
    vn_pkg::result_t r;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned len;
    logic [vn_pkg::IN_WIDTH-1:0] xr;
    logic [vn_pkg::IN_WIDTH-1:0] yr;
    logic [vn_pkg::IN_WIDTH-1:0] xn;
    logic [vn_pkg::IN_WIDTH-1:0] yn;
    xr = v.x_component[vn_pkg::IN_WIDTH-1:0];
    yr = v.y_component[vn_pkg::IN_WIDTH-1:0];
    xn = (~xr) + 1'b1;
    yn = (~yr) + 1'b1;
    ax = xr[vn_pkg::IN_WIDTH-1] ? 64'(xn) : 64'(xr);
    ay = yr[vn_pkg::IN_WIDTH-1] ? 64'(yn) : 64'(yr);
    len = floor_sqrt(ax * ax + ay * ay);
    r.unit_x = scale_component(xr, len);
    r.unit_y = scale_component(yr, len);
    r.length = len[vn_pkg::FIELD_W-1:0];
    r.is_zero = (len == 0);
    return r;
  endfunction

  // Holds pending normalized vectors in arrival order.
  class unit_vector_board;
    vn_pkg::result_t pending[$];
    int errors;

    function void note_vector(vn_pkg::item_t v);
      pending.push_back(normalize_vector(v));
    endfunction

    function void check_result(vn_pkg::result_t got);
      vn_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.unit_x !== want.unit_x) begin
        $display("%0t: unit_x expected %h actual %h", $realtime, want.unit_x, got.unit_x);
        errors++;
      end
      if (got.unit_y !== want.unit_y) begin
        $display("%0t: unit_y expected %h actual %h", $realtime, want.unit_y, got.unit_y);
        errors++;
      end
      if (got.length !== want.length) begin
        $display("%0t: length expected %h actual %h", $realtime, want.length, got.length);
        errors++;
      end
      if (got.is_zero !== want.is_zero) begin
        $display("%0t: is_zero expected %b actual %b", $realtime, want.is_zero, got.is_zero);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 3 + vn_pkg::ROOT_W + vn_pkg::QUO_W + 1;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  vn_pkg::item_t item;
  logic result_valid;
  logic result_ready;
  vn_pkg::result_t result;

  unit_vector_board board;
  int cycle_count;
  bit stim_done;

  vec2_normalize_fixed dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted inputs and check accepted results at the edge they transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) board.note_vector(item);
      if (result_valid && result_ready) board.check_result(result);
    end
  end

  // Stall the receiver: alternate free-running stretches with random stalls.
  initial begin
    int mode;
    result_ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cycle_count % 300 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(0, 3) != 0);
        default: result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Timeout watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Present one transaction and hold it until accepted.
  task automatic send_vector(logic [31:0] x, logic [31:0] y);
    item_valid <= 1'b1;
    item.x_component <= x;
    item.y_component <= y;
    do @(posedge clk); while (!item_ready);
  endtask

  // Drop valid for a random gap between bursts.
  task automatic idle_gap(int cycles);
    item_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [31:0] random_component();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 255) - 128;
      1: return $urandom_range(0, 65535) - 32768;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[6];
    int burst;
    board = new();
    stim_done = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero vector, axes, extremes of each component.
    edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    foreach (edge_vals[i]) send_vector(edge_vals[i], 32'h0);
    foreach (edge_vals[i]) send_vector(32'h0, edge_vals[i]);
    send_vector(32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF);
    send_vector(32'hFFFF_FFFF, 32'h1);
    send_vector(32'h0003_0000, 32'hFFFC_0000);
    idle_gap(2);

    // Random bursts with random gaps; some bursts run back to back.
    for (int n = 0; n < 800; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 800; k++, n++)
        send_vector(random_component(), random_component());
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
    end
    item_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vn_pkg.sv
rtl/vn_square.sv
rtl/vn_sqrt.sv
rtl/vn_div.sv
rtl/vec2_normalize_fixed.sv
rtl/vn_checker.sv
tb/vec2_normalize_fixed_tb.sv
